// ===== src/json_string_escaper_core_assert.svh =====
// Assertion macros shared by the JSON string escaper RTL.
`ifndef JSON_STRING_ESCAPER_CORE_ASSERT_SVH
`define JSON_STRING_ESCAPER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/jse_pkg.sv =====
// Package with shared types, constants and functions of the JSON string escaper.
`default_nettype none

package jse_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam logic [15:0] CAPACITY_RESET = 16'd1024;

    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHAR_U         = 8'h75;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CONTROL_LIMIT  = 8'h20;

    typedef enum logic [1:0] {
        REQ_CLEAR   = 2'd0,
        REQ_OPEN    = 2'd1,
        REQ_CONTENT = 2'd2,
        REQ_CLOSE   = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        PK_PLAIN    = 2'd0,
        PK_SHORT    = 2'd1,
        PK_UNICODE  = 2'd2,
        PK_OVERFLOW = 2'd3
    } piece_kind_t;

    typedef struct packed {
        piece_kind_t kind;
        logic [7:0]  data;
    } piece_t;

    typedef struct packed {
        logic [15:0] used;
        logic        failed;
    } front_status_t;

    function automatic logic [7:0] escape_letter(input logic [7:0] b);
        logic [7:0] letter;
        case (b)
            8'h22:   letter = 8'h22;
            8'h5c:   letter = 8'h5c;
            8'h08:   letter = 8'h62;
            8'h0c:   letter = 8'h66;
            8'h0a:   letter = 8'h6e;
            8'h0d:   letter = 8'h72;
            8'h09:   letter = 8'h74;
            default: letter = 8'h00;
        endcase
        return letter;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nibble);
        logic [7:0] c;
        if (nibble < 4'd10)
        begin
            c = 8'h30 + {4'd0, nibble};
        end
        else
        begin
            c = 8'h57 + {4'd0, nibble};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/jse_front.sv =====
// Front part: accepts requests, classifies them and keeps the buffer fill state.
`default_nettype none

module jse_front
    import jse_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_wr_en,
    input  wire logic [15:0]   cfg_wr_data,
    input  wire logic          in_valid,
    input  wire logic [1:0]    in_req,
    input  wire logic [7:0]    in_byte,
    input  wire logic          q_full,
    output logic               in_ready,
    output logic               push,
    output piece_t             push_piece,
    output front_status_t      status
);

    logic [15:0] cap_reg, cap_next;
    logic [15:0] used_reg, used_next;
    logic        failed_reg, failed_next;

    logic        accept;
    logic [7:0]  letter;
    piece_t      piece;
    logic [2:0]  piece_len;
    logic        fits;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign letter   = escape_letter(in_byte);

    always_comb
    begin
        piece.kind = PK_PLAIN;
        piece.data = CHAR_QUOTE;
        piece_len  = 3'd1;
        if (in_req == REQ_CONTENT)
        begin
            if (letter != 8'h00)
            begin
                piece.kind = PK_SHORT;
                piece.data = letter;
                piece_len  = 3'd2;
            end
            else if (in_byte < CONTROL_LIMIT)
            begin
                piece.kind = PK_UNICODE;
                piece.data = in_byte;
                piece_len  = 3'd6;
            end
            else
            begin
                piece.data = in_byte;
            end
        end
    end

    assign fits = ({1'b0, used_reg} + {14'd0, piece_len}) < {1'b0, cap_reg};

    always_comb
    begin
        cap_next        = cfg_wr_en ? cfg_wr_data : cap_reg;
        used_next       = used_reg;
        failed_next     = failed_reg;
        push            = 1'b0;
        push_piece      = piece;
        if (accept)
        begin
            if (in_req == REQ_CLEAR)
            begin
                used_next   = 16'd0;
                failed_next = 1'b0;
            end
            else if (failed_reg || !fits)
            begin
                failed_next     = 1'b1;
                push            = 1'b1;
                push_piece.kind = PK_OVERFLOW;
                push_piece.data = 8'h00;
            end
            else
            begin
                push      = 1'b1;
                used_next = used_reg + {13'd0, piece_len};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= CAPACITY_RESET;
            used_reg   <= 16'd0;
            failed_reg <= 1'b0;
        end
        else
        begin
            cap_reg    <= cap_next;
            used_reg   <= used_next;
            failed_reg <= failed_next;
        end
    end

    assign status.used   = used_reg;
    assign status.failed = failed_reg;

endmodule

`default_nettype wire

// ===== src/jse_queue.sv =====
// Short queue of classified pieces between the front and back parts.
`default_nettype none

module jse_queue
    import jse_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire piece_t push_piece,
    input  wire logic   pop,
    output logic        full,
    output logic        valid,
    output piece_t      head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    piece_t             slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_piece;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/jse_back.sv =====
// Back part: expands each piece into output bytes behind an output register.
`default_nettype none

module jse_back
    import jse_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire piece_t      q_head,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             out_last,
    output logic             out_overflow
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       ovf_reg, ovf_next;

    logic       advance;
    logic [7:0] cur_byte;
    logic       cur_last;

    assign advance = q_valid && (!valid_reg || out_ready);
    assign pop     = advance && cur_last;

    always_comb
    begin
        cur_byte = q_head.data;
        cur_last = 1'b1;
        case (q_head.kind)
            PK_PLAIN:
            begin
                cur_byte = q_head.data;
                cur_last = 1'b1;
            end
            PK_SHORT:
            begin
                cur_byte = (idx_reg == 3'd0) ? CHAR_BACKSLASH : q_head.data;
                cur_last = (idx_reg != 3'd0);
            end
            PK_UNICODE:
            begin
                cur_last = (idx_reg == 3'd5);
                case (idx_reg)
                    3'd0:    cur_byte = CHAR_BACKSLASH;
                    3'd1:    cur_byte = CHAR_U;
                    3'd2:    cur_byte = CHAR_ZERO;
                    3'd3:    cur_byte = CHAR_ZERO;
                    3'd4:    cur_byte = hex_char(q_head.data[7:4]);
                    default: cur_byte = hex_char(q_head.data[3:0]);
                endcase
            end
            default:
            begin
                cur_byte = 8'h00;
                cur_last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        ovf_next   = ovf_reg;
        if (advance)
        begin
            valid_next = 1'b1;
            byte_next  = cur_byte;
            last_next  = cur_last;
            ovf_next   = (q_head.kind == PK_OVERFLOW);
            idx_next   = cur_last ? 3'd0 : idx_reg + 3'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
            byte_reg  <= 8'h00;
            last_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
            byte_reg  <= byte_next;
            last_reg  <= last_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign out_last     = last_reg;
    assign out_overflow = ovf_reg;

endmodule

`default_nettype wire

// ===== src/json_string_escaper_core.sv =====
// Top level of the JSON string escaper with a bounded output buffer.
//
//   Group   Direction  Payload
//   s_*     in         tuser[1:0] request type, tdata[7:0] raw byte
//   m_*     out        tdata[7:0] escaped byte, tlast end of piece, tuser[0] overflow
//   cfg_*   in         buffer capacity in bytes, terminator included
//
// Plain bytes and quotes expand to one output byte each, two-letter escapes to two,
// and control bytes to six; the single byte-wide output register sends them one by one.
// Requests are taken every cycle while the four-entry piece queue has room.
// Clear requests produce no output.
// Reset empties the queue, zeroes the fill state and sets the capacity to 1024.
`default_nettype none

module json_string_escaper_core
    import jse_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] in_byte
    input  wire logic [1:0]  s_tuser,     // [1:0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,     // [7:0] out_byte
    output logic             m_tlast,
    output logic [0:0]       m_tuser,     // [0] overflow
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    logic          q_full;
    logic          q_valid;
    logic          q_push;
    logic          q_pop;
    piece_t        q_in;
    piece_t        q_head;
    front_status_t status;
    logic          ovf_bit;

    jse_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_req      (s_tuser),
        .in_byte     (s_tdata),
        .q_full      (q_full),
        .in_ready    (s_tready),
        .push        (q_push),
        .push_piece  (q_in),
        .status      (status)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_piece (q_in),
        .pop        (q_pop),
        .full       (q_full),
        .valid      (q_valid),
        .head       (q_head)
    );

    jse_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .pop          (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_byte     (m_tdata),
        .out_last     (m_tlast),
        .out_overflow (ovf_bit)
    );

    assign m_tuser = ovf_bit;

`include "json_string_escaper_core_assert.svh"

    `JSE_ASSERT_NOW(a_overflow_shape, m_tvalid && m_tuser[0], m_tlast && (m_tdata == 8'h00), "overflow result must be a single zero byte marked last")
    `JSE_ASSERT_NEXT(a_clear_resets, s_tvalid && s_tready && (s_tuser == REQ_CLEAR), !status.failed && (status.used == 16'd0), "clear request must empty the buffer state")
    `JSE_ASSERT_NEXT(a_fail_sticky, status.failed && !(s_tvalid && s_tready && (s_tuser == REQ_CLEAR)), status.failed, "failure must hold until a clear request")

endmodule

`default_nettype wire
